// ===== rtl/core/assert_macros.svh =====
// Assertion helpers; define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/pps_pkg.sv =====
package pps_pkg;

    localparam int MAX_PROCESSES = 16;
    localparam int IDX_W  = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int CNT_W  = $clog2(MAX_PROCESSES + 1);
    localparam int DATA_W = 8;
    // latest finish is 255 + MAX_PROCESSES * 255 ticks
    localparam int TIME_W = 15;
    localparam int RES_W  = 14;
    localparam int SUM_W  = 20;
    localparam int PIDX_W = 6;

    localparam logic [RES_W-1:0] RES_MAX = '1;

    typedef struct packed {
        logic [DATA_W-1:0] burst;
        logic [DATA_W-1:0] prio;
        logic [DATA_W-1:0] arrival;
        logic [DATA_W-1:0] remaining;
        logic [TIME_W-1:0] finish;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [4:0] {
        ST_LOAD     = 5'b00001,
        ST_SCAN     = 5'b00010,
        ST_DECIDE   = 5'b00100,
        ST_OUT_RD   = 5'b01000,
        ST_OUT_CALC = 5'b10000
    } state_t;

    function automatic logic [RES_W-1:0] sat_res(input logic [TIME_W-1:0] v);
        logic [TIME_W-1:0] lim;
        lim = {{(TIME_W-RES_W){1'b0}}, RES_MAX};
        if (v > lim)
            return RES_MAX;
        else
            return v[RES_W-1:0];
    endfunction

endpackage

// ===== rtl/core/pps_in_if.sv =====
interface pps_in_if;
    logic                          valid;
    logic                          ready;
    logic [pps_pkg::DATA_W-1:0]    burst;
    logic [pps_pkg::DATA_W-1:0]    prio;
    logic [pps_pkg::DATA_W-1:0]    arrival;
    logic                          is_last;

    modport source (output valid, burst, prio, arrival, is_last, input ready);
    modport sink   (input valid, burst, prio, arrival, is_last, output ready);
endinterface

// ===== rtl/core/pps_out_if.sv =====
interface pps_out_if;
    logic                          valid;
    logic                          ready;
    logic [pps_pkg::PIDX_W-1:0]    process_index;
    logic [pps_pkg::RES_W-1:0]     finish_tick;
    logic [pps_pkg::RES_W-1:0]     turnaround;
    logic [pps_pkg::RES_W-1:0]     waiting;
    logic [pps_pkg::SUM_W-1:0]     sum_waiting;
    logic [pps_pkg::SUM_W-1:0]     sum_turnaround;
    logic                          overflow;
    logic                          final_res;

    modport source (output valid, process_index, finish_tick, turnaround, waiting,
                    sum_waiting, sum_turnaround, overflow, final_res, input ready);
    modport sink   (input valid, process_index, finish_tick, turnaround, waiting,
                    sum_waiting, sum_turnaround, overflow, final_res, output ready);
endinterface

// ===== rtl/core/pps_ram.sv =====
module pps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/preemptive_priority_scheduler_unit.sv =====
// Channel   Dir  Payload                                         Beat
// sched_in  in   burst, prio, arrival, is_last                   one process record
// sched_out out  process_index, finish_tick, turnaround, waiting, one result per process
//                sum_waiting, sum_turnaround, overflow, final_res
//
// Records load at one per cycle while in ST_LOAD into a single process RAM (one read port).
// Each scheduling tick scans all n held records, then ST_DECIDE charges the chosen one.
// Results leave one at a time (RAM read, then compute into output register once it is free).
// Reset (rst_n low, async) empties the batch; RAM contents need no clearing.
// A stalled result holds in the output register; next batch loads while the last one waits.
`include "assert_macros.svh"

module preemptive_priority_scheduler_unit (
    input  logic      clk,
    input  logic      rst_n,
    pps_in_if.sink    sched_in,
    pps_out_if.source sched_out
);

    pps_pkg::state_t                  state_reg, state_next;
    logic [pps_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic [pps_pkg::CNT_W-1:0]        done_reg, done_next;
    logic                             dropped_reg, dropped_next;
    logic [pps_pkg::TIME_W-1:0]       time_reg, time_next;
    logic [pps_pkg::CNT_W-1:0]        scan_idx_reg, scan_idx_next;
    logic                             pend_reg, pend_next;
    logic [pps_pkg::IDX_W-1:0]        pend_idx_reg, pend_idx_next;
    logic                             found_reg, found_next;
    logic [pps_pkg::IDX_W-1:0]        best_idx_reg, best_idx_next;
    pps_pkg::entry_t                  best_reg, best_next;
    logic [pps_pkg::IDX_W-1:0]        out_idx_reg, out_idx_next;
    logic [pps_pkg::SUM_W-1:0]        sum_w_reg, sum_w_next;
    logic [pps_pkg::SUM_W-1:0]        sum_t_reg, sum_t_next;

    logic                             out_valid_reg, out_valid_next;
    logic [pps_pkg::PIDX_W-1:0]       o_idx_reg;
    logic [pps_pkg::RES_W-1:0]        o_fin_reg, o_tat_reg, o_wt_reg;
    logic [pps_pkg::SUM_W-1:0]        o_sw_reg, o_st_reg;
    logic                             o_ovf_reg, o_fin_flag_reg;

    logic                             ram_we, ram_re;
    logic [pps_pkg::IDX_W-1:0]        ram_waddr, ram_raddr;
    pps_pkg::entry_t                  ram_wdata, ram_rdata;

    logic                             in_beat, out_load, issue, cand;
    logic                             stored, is_last_out;
    logic [pps_pkg::DATA_W-1:0]       rem_dec;
    logic [pps_pkg::TIME_W-1:0]       tat_full, wt_full;
    logic [pps_pkg::RES_W-1:0]        fin_sat, tat_sat, wt_sat;

    pps_ram #(
        .WIDTH (pps_pkg::ENTRY_W),
        .DEPTH (pps_pkg::MAX_PROCESSES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign sched_in.ready = (state_reg == pps_pkg::ST_LOAD);
    assign in_beat        = sched_in.valid && sched_in.ready;
    assign stored         = (cnt_reg < pps_pkg::CNT_W'(pps_pkg::MAX_PROCESSES));

    // ready test for the entry whose read data is present this cycle
    assign cand = pend_reg && (ram_rdata.remaining != '0)
                  && ({{(pps_pkg::TIME_W-pps_pkg::DATA_W){1'b0}}, ram_rdata.arrival} <= time_reg);
    assign issue   = (scan_idx_reg < cnt_reg);
    assign rem_dec = best_reg.remaining - 8'd1;

    // result arithmetic; finish never precedes arrival + burst
    assign tat_full = ram_rdata.finish
                      - {{(pps_pkg::TIME_W-pps_pkg::DATA_W){1'b0}}, ram_rdata.arrival};
    assign wt_full  = tat_full
                      - {{(pps_pkg::TIME_W-pps_pkg::DATA_W){1'b0}}, ram_rdata.burst};
    assign fin_sat  = pps_pkg::sat_res(ram_rdata.finish);
    assign tat_sat  = pps_pkg::sat_res(tat_full);
    assign wt_sat   = pps_pkg::sat_res(wt_full);
    assign is_last_out = ((pps_pkg::CNT_W'(out_idx_reg) + pps_pkg::CNT_W'(1)) == cnt_reg);
    assign out_load = (state_reg == pps_pkg::ST_OUT_CALC) && (!out_valid_reg || sched_out.ready);

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        done_next     = done_reg;
        dropped_next  = dropped_reg;
        time_next     = time_reg;
        scan_idx_next = scan_idx_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        found_next    = found_reg;
        best_idx_next = best_idx_reg;
        best_next     = best_reg;
        out_idx_next  = out_idx_reg;
        sum_w_next    = sum_w_reg;
        sum_t_next    = sum_t_reg;
        ram_we        = 1'b0;
        ram_waddr     = cnt_reg[pps_pkg::IDX_W-1:0];
        ram_wdata     = best_reg;
        ram_re        = 1'b0;
        ram_raddr     = scan_idx_reg[pps_pkg::IDX_W-1:0];

        unique case (state_reg)
            pps_pkg::ST_LOAD:
            begin
                if (in_beat)
                begin
                    if (stored)
                    begin
                        ram_we              = 1'b1;
                        ram_wdata.burst     = sched_in.burst;
                        ram_wdata.prio      = sched_in.prio;
                        ram_wdata.arrival   = sched_in.arrival;
                        ram_wdata.remaining = sched_in.burst;
                        // a zero burst finishes at its arrival
                        ram_wdata.finish    = {{(pps_pkg::TIME_W-pps_pkg::DATA_W){1'b0}},
                                               sched_in.arrival};
                        cnt_next            = cnt_reg + pps_pkg::CNT_W'(1);
                        if (sched_in.burst == '0)
                        begin
                            done_next = done_reg + pps_pkg::CNT_W'(1);
                        end
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (sched_in.is_last)
                    begin
                        time_next     = '0;
                        scan_idx_next = '0;
                        found_next    = 1'b0;
                        out_idx_next  = '0;
                        sum_w_next    = '0;
                        sum_t_next    = '0;
                        state_next    = (done_next == cnt_next) ? pps_pkg::ST_OUT_RD
                                                                : pps_pkg::ST_SCAN;
                    end
                end
            end
            pps_pkg::ST_SCAN:
            begin
                if (issue)
                begin
                    ram_re        = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = scan_idx_reg[pps_pkg::IDX_W-1:0];
                    scan_idx_next = scan_idx_reg + pps_pkg::CNT_W'(1);
                end
                else
                begin
                    state_next = pps_pkg::ST_DECIDE;
                end
                // strict compare keeps the lowest index on a tie
                if (cand && (!found_reg || (ram_rdata.prio < best_reg.prio)))
                begin
                    found_next    = 1'b1;
                    best_idx_next = pend_idx_reg;
                    best_next     = ram_rdata;
                end
            end
            pps_pkg::ST_DECIDE:
            begin
                time_next     = time_reg + pps_pkg::TIME_W'(1);
                scan_idx_next = '0;
                found_next    = 1'b0;
                if (found_reg)
                begin
                    ram_we              = 1'b1;
                    ram_waddr           = best_idx_reg;
                    ram_wdata.remaining = rem_dec;
                    if (rem_dec == '0)
                    begin
                        ram_wdata.finish = time_next;
                        done_next        = done_reg + pps_pkg::CNT_W'(1);
                    end
                end
                state_next = (done_next == cnt_reg) ? pps_pkg::ST_OUT_RD : pps_pkg::ST_SCAN;
            end
            pps_pkg::ST_OUT_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = out_idx_reg;
                state_next = pps_pkg::ST_OUT_CALC;
            end
            pps_pkg::ST_OUT_CALC:
            begin
                if (out_load)
                begin
                    sum_w_next   = sum_w_reg + pps_pkg::SUM_W'(wt_sat);
                    sum_t_next   = sum_t_reg + pps_pkg::SUM_W'(tat_sat);
                    out_idx_next = out_idx_reg + pps_pkg::IDX_W'(1);
                    if (is_last_out)
                    begin
                        // drop the batch, ready for the next one
                        cnt_next     = '0;
                        done_next    = '0;
                        dropped_next = 1'b0;
                        time_next    = '0;
                        state_next   = pps_pkg::ST_LOAD;
                    end
                    else
                    begin
                        state_next = pps_pkg::ST_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = pps_pkg::ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (sched_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pps_pkg::ST_LOAD;
            cnt_reg       <= '0;
            done_reg      <= '0;
            dropped_reg   <= 1'b0;
            time_reg      <= '0;
            scan_idx_reg  <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            out_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            done_reg      <= done_next;
            dropped_reg   <= dropped_next;
            time_reg      <= time_next;
            scan_idx_reg  <= scan_idx_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            out_idx_reg   <= out_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        best_idx_reg <= best_idx_next;
        best_reg     <= best_next;
        sum_w_reg    <= sum_w_next;
        sum_t_reg    <= sum_t_next;
        if (out_load)
        begin
            o_idx_reg      <= pps_pkg::PIDX_W'(out_idx_reg);
            o_fin_reg      <= fin_sat;
            o_tat_reg      <= tat_sat;
            o_wt_reg       <= wt_sat;
            o_sw_reg       <= sum_w_next;
            o_st_reg       <= sum_t_next;
            o_ovf_reg      <= dropped_reg;
            o_fin_flag_reg <= is_last_out;
        end
    end

    assign sched_out.valid          = out_valid_reg;
    assign sched_out.process_index  = o_idx_reg;
    assign sched_out.finish_tick    = o_fin_reg;
    assign sched_out.turnaround     = o_tat_reg;
    assign sched_out.waiting        = o_wt_reg;
    assign sched_out.sum_waiting    = o_sw_reg;
    assign sched_out.sum_turnaround = o_st_reg;
    assign sched_out.overflow       = o_ovf_reg;
    assign sched_out.final_res      = o_fin_flag_reg;

    `ASSERT_IMPL(a_done_le_cnt, clk, rst_n, state_reg != pps_pkg::ST_LOAD, done_reg <= cnt_reg)
    `ASSERT_IMPL(a_pick_unfinished, clk, rst_n, (state_reg == pps_pkg::ST_DECIDE) && found_reg, best_reg.remaining != '0)
    `ASSERT_IMPL(a_out_slot_free, clk, rst_n, out_load, !out_valid_reg || sched_out.ready)
    `ASSERT_NEXT(a_scan_no_write, clk, rst_n, state_reg == pps_pkg::ST_SCAN, state_reg == pps_pkg::ST_SCAN || state_reg == pps_pkg::ST_DECIDE)
    `ASSERT_IMPL(a_out_idx_range, clk, rst_n, state_reg == pps_pkg::ST_OUT_RD, pps_pkg::CNT_W'(out_idx_reg) < cnt_reg)

endmodule

// ===== tb/sv/preemptive_priority_scheduler_unit_test.sv =====
`timescale 1ns / 1ps

module preemptive_priority_scheduler_unit_test;

    typedef struct {
        logic [pps_pkg::PIDX_W-1:0] process_index;
        logic [pps_pkg::RES_W-1:0]  finish_tick;
        logic [pps_pkg::RES_W-1:0]  turnaround;
        logic [pps_pkg::RES_W-1:0]  waiting;
        logic [pps_pkg::SUM_W-1:0]  sum_waiting;
        logic [pps_pkg::SUM_W-1:0]  sum_turnaround;
        logic                       overflow;
        logic                       final_res;
    } sched_result_t;

    class sched_checker;
        logic [pps_pkg::DATA_W-1:0] burst_mem[pps_pkg::MAX_PROCESSES];
        logic [pps_pkg::DATA_W-1:0] prio_mem[pps_pkg::MAX_PROCESSES];
        logic [pps_pkg::DATA_W-1:0] arrival_mem[pps_pkg::MAX_PROCESSES];
        int unsigned       held;
        bit                dropped;
        sched_result_t     expected_results[$];
        int unsigned       errors;
        int unsigned       batches;
        int unsigned       overflow_batches;
        int unsigned       results_checked;

        function logic [pps_pkg::RES_W-1:0] clamp14(int unsigned v);
            if (v > 16383)
                return {pps_pkg::RES_W{1'b1}};
            else
                return v[pps_pkg::RES_W-1:0];
        endfunction

        // Replay the batch tick by tick and queue one result per held record.
        function void compute_schedule();
            int unsigned   remain[pps_pkg::MAX_PROCESSES];
            int unsigned   fin[pps_pkg::MAX_PROCESSES];
            int unsigned   done;
            int unsigned   tick_now;
            int unsigned   tat;
            int unsigned   wt;
            int            sel;
            logic [pps_pkg::SUM_W-1:0] sum_w;
            logic [pps_pkg::SUM_W-1:0] sum_t;
            sched_result_t r;
            done = 0;
            tick_now = 0;
            for (int i = 0; i < held; i++)
            begin
                remain[i] = 32'(burst_mem[i]);
                if (burst_mem[i] == '0)
                begin
                    fin[i] = 32'(arrival_mem[i]);
                    done++;
                end
            end
            while (done < held)
            begin
                sel = -1;
                for (int i = 0; i < held; i++)
                begin
                    if (remain[i] != 0 && 32'(arrival_mem[i]) <= tick_now &&
                        (sel < 0 || prio_mem[i] < prio_mem[sel]))
                        sel = i;
                end
                tick_now++;
                if (sel >= 0)
                begin
                    remain[sel]--;
                    if (remain[sel] == 0)
                    begin
                        fin[sel] = tick_now;
                        done++;
                    end
                end
            end
            sum_w = '0;
            sum_t = '0;
            for (int i = 0; i < held; i++)
            begin
                tat = fin[i] - 32'(arrival_mem[i]);
                wt = tat - 32'(burst_mem[i]);
                sum_w = sum_w + pps_pkg::SUM_W'(clamp14(wt));
                sum_t = sum_t + pps_pkg::SUM_W'(clamp14(tat));
                r.process_index  = i[pps_pkg::PIDX_W-1:0];
                r.finish_tick    = clamp14(fin[i]);
                r.turnaround     = clamp14(tat);
                r.waiting        = clamp14(wt);
                r.sum_waiting    = sum_w;
                r.sum_turnaround = sum_t;
                r.overflow       = dropped;
                r.final_res      = (i + 1 == held);
                expected_results.push_back(r);
            end
        endfunction

        function void load_record(logic [pps_pkg::DATA_W-1:0] b,
                                  logic [pps_pkg::DATA_W-1:0] p,
                                  logic [pps_pkg::DATA_W-1:0] a, logic last);
            if (held < pps_pkg::MAX_PROCESSES)
            begin
                burst_mem[held] = b;
                prio_mem[held] = p;
                arrival_mem[held] = a;
                held++;
            end
            else
                dropped = 1;
            if (last)
            begin
                compute_schedule();
                batches++;
                if (dropped)
                    overflow_batches++;
                held = 0;
                dropped = 0;
            end
        endfunction

        function void compare_field(string fname, logic [pps_pkg::SUM_W-1:0] want,
                                    logic [pps_pkg::SUM_W-1:0] got);
            if (got !== want)
            begin
                $display("%0t ns: mismatch on %s: expected %0d, actual %0d",
                         $time, fname, want, got);
                errors++;
            end
        endfunction

        function void check_result(sched_result_t got);
            sched_result_t want;
            if (expected_results.size() == 0)
            begin
                $display("%0t ns: result for process %0d with none expected",
                         $time, got.process_index);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            results_checked++;
            compare_field("process_index", pps_pkg::SUM_W'(want.process_index),
                          pps_pkg::SUM_W'(got.process_index));
            compare_field("finish_tick", pps_pkg::SUM_W'(want.finish_tick),
                          pps_pkg::SUM_W'(got.finish_tick));
            compare_field("turnaround", pps_pkg::SUM_W'(want.turnaround),
                          pps_pkg::SUM_W'(got.turnaround));
            compare_field("waiting", pps_pkg::SUM_W'(want.waiting),
                          pps_pkg::SUM_W'(got.waiting));
            compare_field("sum_waiting", want.sum_waiting, got.sum_waiting);
            compare_field("sum_turnaround", want.sum_turnaround, got.sum_turnaround);
            compare_field("overflow", pps_pkg::SUM_W'(want.overflow),
                          pps_pkg::SUM_W'(got.overflow));
            compare_field("final_res", pps_pkg::SUM_W'(want.final_res),
                          pps_pkg::SUM_W'(got.final_res));
        endfunction
    endclass

    logic clk;
    logic rst_n;

    pps_in_if  in_ch();
    pps_out_if out_ch();

    preemptive_priority_scheduler_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sched_in  (in_ch),
        .sched_out (out_ch)
    );

    sched_checker sched_chk;
    int unsigned  records_sent;
    int unsigned  random_records;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #40000000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    task automatic send_record(input logic [pps_pkg::DATA_W-1:0] b,
                               input logic [pps_pkg::DATA_W-1:0] p,
                               input logic [pps_pkg::DATA_W-1:0] a, input logic last);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.burst   <= b;
        in_ch.prio    <= p;
        in_ch.arrival <= a;
        in_ch.is_last <= last;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sched_chk.load_record(b, p, a, last);
        records_sent++;
    endtask

    // Hold the input side until every queued result has left the block.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (sched_chk.expected_results.size() != 0);
    endtask

    task automatic send_random_batch();
        int unsigned r;
        int unsigned n;
        logic [pps_pkg::DATA_W-1:0] b;
        logic [pps_pkg::DATA_W-1:0] p;
        logic [pps_pkg::DATA_W-1:0] a;
        r = $urandom_range(0, 99);
        if (r < 70)
            n = $urandom_range(1, 8);
        else if (r < 90)
            n = $urandom_range(9, 16);
        else
            n = $urandom_range(17, 20);
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 5)
                b = '0;
            else if (r < 82)
                b = pps_pkg::DATA_W'($urandom_range(1, 16));
            else
                b = pps_pkg::DATA_W'($urandom_range(0, 255));
            p = pps_pkg::DATA_W'(($urandom_range(0, 99) < 60) ? $urandom_range(0, 7)
                                                              : $urandom_range(0, 255));
            a = pps_pkg::DATA_W'(($urandom_range(0, 99) < 70) ? $urandom_range(0, 31)
                                                              : $urandom_range(0, 255));
            send_record(b, p, a, i == n - 1);
            random_records++;
        end
    endtask

    initial
    begin
        sched_chk = new;
        records_sent = 0;
        random_records = 0;
        rst_n <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.burst   <= '0;
        in_ch.prio    <= '0;
        in_ch.arrival <= '0;
        in_ch.is_last <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // single record at the top of every field
        send_record(8'd255, 8'd255, 8'd255, 1'b1);

        // zero burst, equal priorities, preemption, then an idle stretch
        send_record(8'd0, 8'd9, 8'd200, 1'b0);
        send_record(8'd5, 8'd7, 8'd0, 1'b0);
        send_record(8'd3, 8'd7, 8'd0, 1'b0);
        send_record(8'd2, 8'd1, 8'd2, 1'b0);
        send_record(8'd4, 8'd0, 8'd30, 1'b1);
        wait_drained();

        // one record past capacity; the dropped one carries the last flag
        for (int i = 0; i < pps_pkg::MAX_PROCESSES + 1; i++)
        begin
            if (i == 0)
                send_record(8'd255, 8'd0, 8'd0, 1'b0);
            else if (i == 1)
                send_record(8'd1, 8'd255, 8'd255, 1'b0);
            else
                send_record(pps_pkg::DATA_W'($urandom_range(1, 255)),
                            pps_pkg::DATA_W'($urandom_range(0, 255)),
                            pps_pkg::DATA_W'($urandom_range(0, 255)),
                            i == pps_pkg::MAX_PROCESSES);
        end

        while (random_records < 190)
        begin
            send_random_batch();
            if ($urandom_range(0, 9) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (100) @(posedge clk);
        $display("Loaded %0d records in %0d batches (%0d over capacity), %0d results checked",
                 records_sent, sched_chk.batches, sched_chk.overflow_batches,
                 sched_chk.results_checked);
        if (sched_chk.errors == 0 && sched_chk.expected_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin : result_sink
        int unsigned run;
        bit          level;
        run = 0;
        level = 1'b1;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (run == 0)
            begin
                level = ~level;
                if (level)
                    run = $urandom_range(1, 30);
                else if ($urandom_range(0, 99) < 80)
                    run = $urandom_range(1, 3);
                else
                    run = $urandom_range(15, 60);
            end
            run--;
            out_ch.ready <= level;
        end
    end

    always @(posedge clk)
    begin : result_monitor
        sched_result_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.process_index  = out_ch.process_index;
            got.finish_tick    = out_ch.finish_tick;
            got.turnaround     = out_ch.turnaround;
            got.waiting        = out_ch.waiting;
            got.sum_waiting    = out_ch.sum_waiting;
            got.sum_turnaround = out_ch.sum_turnaround;
            got.overflow       = out_ch.overflow;
            got.final_res      = out_ch.final_res;
            sched_chk.check_result(got);
        end
    end

endmodule
